// ===== rtl/pse_pkg.sv =====
// Shared types, codes and beat layout for the postfix stack evaluator.
package pse_pkg;

    localparam int STACK_DEPTH_DEF = 64;
    localparam int WORD_W          = 32;
    localparam int OP_W            = 3;
    localparam int DEPTH_W         = 7;
    localparam int STATUS_W        = 3;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;
    localparam int S_PAD_W   = S_TDATA_W - WORD_W - OP_W;
    localparam int M_PAD_W   = M_TDATA_W - WORD_W - DEPTH_W - STATUS_W;

    localparam logic REQ_PUSH = 1'b0;
    localparam logic REQ_OPER = 1'b1;

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 3'd0,
        OP_SUB = 3'd1,
        OP_MUL = 3'd2,
        OP_DIV = 3'd3,
        OP_POW = 3'd4
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_OVERFLOW  = 3'd1,
        STAT_UNDERFLOW = 3'd2,
        STAT_DIVZERO   = 3'd3,
        STAT_BADOP     = 3'd4
    } status_t;

endpackage

// ===== rtl/postfix_stack_evaluator.sv =====
// Postfix stack evaluator: operand stack, shared add/sub and multiply unit, sequencer.
//
// channel | dir | tdata (low bit up)                         | tuser
// s_      | in  | operand_value[31:0], op_code[34:32], zeros | req_type (0 push, 1 operator)
// m_      | out | top_value[31:0], stack_depth[38:32],       | none
//         |     | status[41:39], zeros                       |
//
// Push, overflow, underflow and bad code go from idle to finish; add, sub, mul, divide by zero
// and power with a negative exponent finish from read; divide runs the bit-per-cycle divider
// in exec, and other power the single multiplier, per exponent bit up to its highest set bit.
// Reset clears the sequencer, stack count and output valid; stack storage is not cleared.
// s_tready is high only while the sequencer is idle; a finished result waits in
// the output register, and the next beat is taken while it waits.
module postfix_stack_evaluator #(
    parameter int STACK_DEPTH = pse_pkg::STACK_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operand_value[31:0], op_code[34:32], zero pad
    input  logic [pse_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // top_value[31:0], stack_depth[38:32], status[41:39], zero pad
    output logic [pse_pkg::M_TDATA_W-1:0] m_tdata
);
    import pse_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic [3:0] {
        FSM_IDLE   = 4'b0001,
        FSM_READ   = 4'b0010,
        FSM_EXEC   = 4'b0100,
        FSM_FINISH = 4'b1000
    } fsm_t;

    fsm_t              state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [WORD_W-1:0] top_reg, top_next;
    status_t           status_reg, status_next;
    logic [OP_W-1:0]   op_reg, op_next;
    logic [WORD_W-1:0] right_reg, right_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] aux_reg, aux_next;
    logic              neg_reg, neg_next;
    logic [4:0]        step_reg, step_next;
    logic              phase_reg, phase_next;
    logic              m_valid_reg, m_valid_next;
    logic [WORD_W-1:0] out_top_reg;
    logic [DEPTH_W-1:0] out_depth_reg;
    status_t           out_status_reg;

    logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;
    logic              mem_we;

    logic [WORD_W-1:0] in_value;
    logic [OP_W-1:0]   in_op;
    logic              s_fire;
    logic              out_load;
    logic [CW-1:0]     count_m1, count_m2;
    logic [CW+DEPTH_W-1:0] depth_ext;

    logic              alu_sub;
    logic [WORD_W:0]   alu_a, alu_b, alu_y;
    logic [WORD_W-1:0] mul_a, mul_b, mul_p;
    logic [WORD_W:0]   rem_sh;
    logic [WORD_W-1:0] quot_sh;

    assign in_value  = s_tdata[WORD_W-1:0];
    assign in_op     = s_tdata[WORD_W+OP_W-1:WORD_W];
    assign s_tready  = (state_reg == FSM_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_load  = (state_reg == FSM_FINISH) && (!m_valid_reg || m_tready);
    assign count_m1  = count_reg - CW'(1);
    assign count_m2  = count_reg - CW'(2);
    assign depth_ext = {{DEPTH_W{1'b0}}, count_reg};

    assign alu_y   = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    assign mul_p   = mul_a * mul_b;
    assign rem_sh  = {aux_reg, acc_reg[WORD_W-1]};
    assign quot_sh = {acc_reg[WORD_W-2:0], ~alu_y[WORD_W]};

    always_comb begin
        alu_sub = 1'b0;
        alu_a   = '0;
        alu_b   = '0;
        mul_a   = rd_data_reg;
        mul_b   = right_reg;
        if (state_reg == FSM_READ) begin
            alu_sub = (op_reg == OP_SUB);
            alu_a   = {1'b0, rd_data_reg};
            alu_b   = {1'b0, right_reg};
        end else if (state_reg == FSM_EXEC && op_reg == OP_DIV) begin
            alu_sub = 1'b1;
            alu_a   = rem_sh;
            alu_b   = {1'b0, right_reg};
        end
        if (state_reg == FSM_EXEC) begin
            mul_a = phase_reg ? aux_reg : acc_reg;
            mul_b = aux_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        top_next     = top_reg;
        status_next  = status_reg;
        op_next      = op_reg;
        right_next   = right_reg;
        acc_next     = acc_reg;
        aux_next     = aux_reg;
        neg_next     = neg_reg;
        step_next    = step_reg;
        phase_next   = phase_reg;
        mem_we       = 1'b0;
        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            FSM_IDLE: begin
                if (s_fire) begin
                    status_next = STAT_OK;
                    op_next     = in_op;
                    right_next  = top_reg;
                    state_next  = FSM_FINISH;
                    if (s_tuser == REQ_PUSH) begin
                        if (count_reg >= CW'(STACK_DEPTH)) begin
                            status_next = STAT_OVERFLOW;
                        end else begin
                            mem_we     = (count_reg != '0);
                            top_next   = in_value;
                            count_next = count_reg + CW'(1);
                        end
                    end else if (in_op > OP_POW) begin
                        status_next = STAT_BADOP;
                    end else if (count_reg < CW'(2)) begin
                        status_next = STAT_UNDERFLOW;
                    end else begin
                        state_next = FSM_READ;
                    end
                end
            end
            FSM_READ: begin
                state_next = FSM_FINISH;
                unique case (op_reg)
                    OP_ADD, OP_SUB: begin
                        top_next   = alu_y[WORD_W-1:0];
                        count_next = count_m1;
                    end
                    OP_MUL: begin
                        top_next   = mul_p;
                        count_next = count_m1;
                    end
                    OP_DIV: begin
                        if (right_reg == '0) begin
                            status_next = STAT_DIVZERO;
                        end else begin
                            acc_next   = rd_data_reg[WORD_W-1] ? -rd_data_reg : rd_data_reg;
                            right_next = right_reg[WORD_W-1] ? -right_reg : right_reg;
                            neg_next   = rd_data_reg[WORD_W-1] ^ right_reg[WORD_W-1];
                            aux_next   = '0;
                            step_next  = '0;
                            phase_next = 1'b0;
                            state_next = FSM_EXEC;
                        end
                    end
                    default: begin
                        if (right_reg[WORD_W-1]) begin
                            count_next = count_m1;
                            if (rd_data_reg == WORD_W'(1)) begin
                                top_next = WORD_W'(1);
                            end else if (rd_data_reg == '1) begin
                                top_next = right_reg[0] ? '1 : WORD_W'(1);
                            end else begin
                                top_next = '0;
                            end
                        end else begin
                            acc_next   = WORD_W'(1);
                            aux_next   = rd_data_reg;
                            phase_next = 1'b0;
                            state_next = FSM_EXEC;
                        end
                    end
                endcase
            end
            FSM_EXEC: begin
                if (op_reg == OP_DIV) begin
                    if (phase_reg) begin
                        top_next   = neg_reg ? -acc_reg : acc_reg;
                        count_next = count_m1;
                        state_next = FSM_FINISH;
                    end else begin
                        acc_next  = quot_sh;
                        aux_next  = alu_y[WORD_W] ? rem_sh[WORD_W-1:0] : alu_y[WORD_W-1:0];
                        step_next = step_reg + 5'd1;
                        if (step_reg == '1) begin
                            phase_next = 1'b1;
                        end
                    end
                end else if (!phase_reg) begin
                    if (right_reg == '0) begin
                        top_next   = acc_reg;
                        count_next = count_m1;
                        state_next = FSM_FINISH;
                    end else begin
                        if (right_reg[0]) begin
                            acc_next = mul_p;
                        end
                        phase_next = 1'b1;
                    end
                end else begin
                    aux_next   = mul_p;
                    right_next = right_reg >> 1;
                    phase_next = 1'b0;
                end
            end
            FSM_FINISH: begin
                if (out_load) begin
                    m_valid_next = 1'b1;
                    state_next   = FSM_IDLE;
                end
            end
            default: begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= FSM_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
        top_reg    <= top_next;
        status_reg <= status_next;
        op_reg     <= op_next;
        right_reg  <= right_next;
        acc_reg    <= acc_next;
        aux_reg    <= aux_next;
        neg_reg    <= neg_next;
        step_reg   <= step_next;
        phase_reg  <= phase_next;
        if (out_load) begin
            out_top_reg    <= (count_reg != '0) ? top_reg : '0;
            out_depth_reg  <= depth_ext[DEPTH_W-1:0];
            out_status_reg <= status_reg;
        end
    end

    // entries below the top word; top lives in top_reg
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            stack_mem[count_m1[AW-1:0]] <= top_reg;
        end
        rd_data_reg <= stack_mem[count_m2[AW-1:0]];
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_status_reg, out_depth_reg, out_top_reg};

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(STACK_DEPTH))
        else $error("stack count beyond depth");

    a_exec_operands: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == FSM_READ || state_reg == FSM_EXEC) |-> count_reg >= CW'(2))
        else $error("operator running with fewer than two entries");

    a_underflow_depth: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && out_status_reg == STAT_UNDERFLOW) |-> out_depth_reg < DEPTH_W'(2))
        else $error("underflow reported with two or more entries");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == REQ_OPER) |=> (!s_tready && $stable(count_reg)))
        else $error("stack count changed on an operator accept, or still ready");

endmodule
